/* hdl/hca_pkg.sv */
package hca_pkg;

   localparam int NODE_W            = 10;
   localparam int DIST_W            = 11;
   localparam int TABLE_DEPTH       = 1024;
   localparam int MAX_NODES_DEFAULT = 1024;

   typedef struct packed {
      logic              action;
      logic [NODE_W-1:0] entry_node;
      logic [NODE_W-1:0] entry_parent;
      logic [NODE_W-1:0] entry_depth;
      logic [NODE_W-1:0] entry_chain_top;
      logic [NODE_W-1:0] first_node;
      logic [NODE_W-1:0] second_node;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] ancestor;
      logic [DIST_W-1:0] distance;
      logic              fault;
   } rsp_type;

   // one table row: all three per-node tables share an address
   typedef struct packed {
      logic [NODE_W-1:0] parent;
      logic [NODE_W-1:0] depth;
      logic [NODE_W-1:0] chain_top;
   } entry_type;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_A,
      ST_RD_B,
      ST_RD_TU,
      ST_RD_TV,
      ST_CAP_TV,
      ST_CMP,
      ST_NODE,
      ST_TOPR
   } ctrl_state_type;

   typedef enum logic [2:0] {
      ADDR_ENTRY,
      ADDR_U_NODE,
      ADDR_V_NODE,
      ADDR_U_TOP,
      ADDR_V_TOP,
      ADDR_LIFT,
      ADDR_RD_TOP
   } addr_sel_type;

   typedef struct packed {
      addr_sel_type addr_sel;
      logic         wr;
      logic         ld_query;
      logic         cap_dep_a;
      logic         cap_dep_b;
      logic         cap_u_node;
      logic         cap_v_node;
      logic         cap_u_top;
      logic         cap_v_top;
      logic         lift;
      logic         fin_ok;
      logic         fin_fault;
   } cmd_type;

   typedef struct packed {
      logic tops_equal;
      logic jump_limit;
   } status_type;

endpackage

/* hdl/hca_ram.sv */
module hca_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/hca_datapath.sv */
module hca_datapath #(
   parameter int MAX_NODES = hca_pkg::MAX_NODES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  hca_pkg::req_type    req,
   input  hca_pkg::cmd_type    cmd,
   output hca_pkg::status_type status,
   output hca_pkg::rsp_type    rsp,
   output logic                rsp_strobe
);
   import hca_pkg::*;

   localparam int JUMP_W = $clog2(MAX_NODES + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);

   logic [ADDR_W-1:0] ram_addr;
   entry_type         wr_entry;
   entry_type         rd_entry;

   // u receives the lifted node, v holds the other side
   logic [NODE_W-1:0] u_node_ff, u_dep_ff, u_top_ff, u_tdep_ff, u_tpar_ff;
   logic [NODE_W-1:0] v_node_ff, v_dep_ff, v_top_ff, v_tdep_ff, v_tpar_ff;
   logic [NODE_W-1:0] dep_a_ff, dep_b_ff;
   logic [JUMP_W-1:0] jumps_ff;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_strobe_ff;

   logic              lift_v;
   logic [NODE_W-1:0] lift_node;
   logic [NODE_W-1:0] anc_node, anc_dep;
   logic [DIST_W-1:0] dep_sum, anc_twice;

   assign lift_v    = u_tdep_ff < v_tdep_ff;
   assign lift_node = lift_v ? v_tpar_ff : u_tpar_ff;

   always_comb begin
      case (cmd.addr_sel)
         ADDR_ENTRY:  ram_addr = ADDR_W'(req.entry_node);
         ADDR_U_NODE: ram_addr = ADDR_W'(u_node_ff);
         ADDR_V_NODE: ram_addr = ADDR_W'(v_node_ff);
         ADDR_U_TOP:  ram_addr = ADDR_W'(u_top_ff);
         ADDR_V_TOP:  ram_addr = ADDR_W'(v_top_ff);
         ADDR_LIFT:   ram_addr = ADDR_W'(lift_node);
         ADDR_RD_TOP: ram_addr = ADDR_W'(rd_entry.chain_top);
         default:     ram_addr = '0;
      endcase
   end

   assign wr_entry.parent    = req.entry_parent;
   assign wr_entry.depth     = req.entry_depth;
   assign wr_entry.chain_top = req.entry_chain_top;

   hca_ram #(
      .WIDTH($bits(entry_type)),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (cmd.wr),
      .addr   (ram_addr),
      .wr_data(wr_entry),
      .rd_data(rd_entry)
   );

   always_ff @(posedge clock) begin
      if (cmd.ld_query) begin
         u_node_ff <= req.first_node;
         v_node_ff <= req.second_node;
      end
      if (cmd.cap_dep_a) begin
         dep_a_ff <= rd_entry.depth;
      end
      if (cmd.cap_dep_b) begin
         dep_b_ff <= rd_entry.depth;
      end
      if (cmd.cap_u_node) begin
         u_dep_ff <= rd_entry.depth;
         u_top_ff <= rd_entry.chain_top;
      end
      if (cmd.cap_v_node) begin
         v_dep_ff <= rd_entry.depth;
         v_top_ff <= rd_entry.chain_top;
      end
      if (cmd.cap_u_top) begin
         u_tdep_ff <= rd_entry.depth;
         u_tpar_ff <= rd_entry.parent;
      end
      if (cmd.cap_v_top) begin
         v_tdep_ff <= rd_entry.depth;
         v_tpar_ff <= rd_entry.parent;
      end
      if (cmd.lift) begin
         // deeper chain top goes up; the other side keeps its cached top
         u_node_ff <= lift_node;
         if (lift_v) begin
            v_node_ff <= u_node_ff;
            v_dep_ff  <= u_dep_ff;
            v_top_ff  <= u_top_ff;
            v_tdep_ff <= u_tdep_ff;
            v_tpar_ff <= u_tpar_ff;
         end
      end
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jumps_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.ld_query) begin
            jumps_ff <= '0;
         end else if (cmd.lift) begin
            jumps_ff <= jumps_ff + JUMP_W'(1);
         end
         rsp_strobe_ff <= cmd.fin_ok | cmd.fin_fault;
      end
   end

   // shared chain reached: shallower node is the ancestor
   assign anc_node  = (u_dep_ff < v_dep_ff) ? u_node_ff : v_node_ff;
   assign anc_dep   = (u_dep_ff < v_dep_ff) ? u_dep_ff : v_dep_ff;
   assign dep_sum   = DIST_W'(dep_a_ff) + DIST_W'(dep_b_ff);
   assign anc_twice = {anc_dep, 1'b0};

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.fin_fault) begin
         rsp_in.ancestor = '0;
         rsp_in.distance = '0;
         rsp_in.fault    = 1'b1;
      end else if (cmd.fin_ok) begin
         rsp_in.ancestor = anc_node;
         rsp_in.distance = (dep_sum >= anc_twice) ? (dep_sum - anc_twice) : '0;
         rsp_in.fault    = 1'b0;
      end
   end

   assign status.tops_equal = u_top_ff == v_top_ff;
   assign status.jump_limit = jumps_ff >= JUMP_W'(MAX_NODES);

   assign rsp        = rsp_ff;
   assign rsp_strobe = rsp_strobe_ff;

endmodule

/* hdl/hca_ctrl.sv */
module hca_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                action,
   input  hca_pkg::status_type status,
   output hca_pkg::cmd_type    cmd,
   output logic                busy
);
   import hca_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.addr_sel = ADDR_U_NODE;
      case (state_ff)
         ST_IDLE: begin
            cmd.addr_sel = ADDR_ENTRY;
            if (start) begin
               if (action == ACTION_QUERY) begin
                  cmd.ld_query = 1'b1;
                  state_in     = ST_RD_A;
               end else begin
                  cmd.wr = 1'b1;
               end
            end
         end
         ST_RD_A: begin
            cmd.addr_sel = ADDR_U_NODE;
            state_in     = ST_RD_B;
         end
         ST_RD_B: begin
            cmd.addr_sel   = ADDR_V_NODE;
            cmd.cap_u_node = 1'b1;
            cmd.cap_dep_a  = 1'b1;
            state_in       = ST_RD_TU;
         end
         ST_RD_TU: begin
            cmd.addr_sel   = ADDR_U_TOP;
            cmd.cap_v_node = 1'b1;
            cmd.cap_dep_b  = 1'b1;
            state_in       = ST_RD_TV;
         end
         ST_RD_TV: begin
            cmd.addr_sel  = ADDR_V_TOP;
            cmd.cap_u_top = 1'b1;
            state_in      = ST_CAP_TV;
         end
         ST_CAP_TV: begin
            cmd.cap_v_top = 1'b1;
            state_in      = ST_CMP;
         end
         ST_CMP: begin
            if (status.tops_equal) begin
               cmd.fin_ok = 1'b1;
               state_in   = ST_IDLE;
            end else if (status.jump_limit) begin
               cmd.fin_fault = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.addr_sel = ADDR_LIFT;
               cmd.lift     = 1'b1;
               state_in     = ST_NODE;
            end
         end
         ST_NODE: begin
            cmd.addr_sel   = ADDR_RD_TOP;
            cmd.cap_u_node = 1'b1;
            state_in       = ST_TOPR;
         end
         ST_TOPR: begin
            cmd.cap_u_top = 1'b1;
            state_in      = ST_CMP;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = state_ff != ST_IDLE;

endmodule

/* hdl/heavy_chain_ancestor_query.sv */
// Heavy-chain lowest common ancestor and edge distance.
// Input channel: req carries one beat, taken at a rising edge with start high
//    and busy low. action = write stores parent, depth and chain top of
//    entry_node in one table row (busy stays low, no result).
//    action = query names first_node and second_node.
// Result channel: rsp is valid for exactly one cycle while rsp_strobe is
//    high; the receiver cannot stall, so it must take the beat then.
// Query flow: the rows of both nodes are read, then the rows of both chain
//    tops, then the tops are compared; chain jumps repeat until they match.
//    The three tables share one single-port RAM with registered read;
//    each jump costs a read of the lifted node, a read of its chain top
//    and a compare. The strobe is registered from the final compare.
// Throughput: one query at a time; a new beat is taken in the cycle the
//    result is shown. Writes go at one per cycle.
// A walk that would exceed MAX_NODES jumps ends with fault set, ancestor
//    and distance zero. A distance that would go negative reads as zero.
// Reset clears the controller and the strobe; table contents are undefined
//    until written, and no clearing pass runs.
module heavy_chain_ancestor_query #(
   parameter int MAX_NODES = hca_pkg::MAX_NODES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hca_pkg::req_type req,
   output logic             rsp_strobe,
   output hca_pkg::rsp_type rsp
);
   import hca_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequencer: walks the table reads and decides lift / finish / fault
   hca_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .action(req.action),
      .status(status),
      .cmd   (cmd),
      .busy  (busy)
   );

   // table RAM, per-side node / chain-top cache, jump count, result beat
   hca_datapath #(
      .MAX_NODES(MAX_NODES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .status    (status),
      .rsp       (rsp),
      .rsp_strobe(rsp_strobe)
   );

endmodule
